@@ sv/bgl_pkg.sv @@
// Shared constants and types for the binary GCD and LCM block.
`timescale 1ns / 1ps
`default_nettype none
package bgl_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int IN_W              = 32;
	localparam int GCD_W             = 32;
	localparam int LCM_W             = 63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} bgl_state_t;

endpackage
`default_nettype wire

@@ sv/bgl_gcd.sv @@
// Iterative binary GCD unit, one shift or subtract step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bgl_gcd
	import bgl_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] x_in,
	input  wire logic [W-1:0] y_in,
	output logic              done,
	output logic [W-1:0]      gcd
);

	localparam int SW = $clog2(W + 1);

	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [SW-1:0] sh_q;
	logic          busy_q;
	logic          finish;
	logic          x_lt_y;

	assign finish = (x_q == '0) || (y_q == '0);
	assign x_lt_y = x_q < y_q;
	assign done   = busy_q && finish;
	assign gcd    = (x_q | y_q) << sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= x_in;
			y_q  <= y_in;
			sh_q <= '0;
		end else if (busy_q && !finish) begin
			priority if (!x_q[0] && !y_q[0]) begin
				x_q  <= x_q >> 1;
				y_q  <= y_q >> 1;
				sh_q <= sh_q + SW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_lt_y) begin
				y_q <= (y_q - x_q) >> 1;
			end else begin
				x_q <= (x_q - y_q) >> 1;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/bgl_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bgl_div
	import bgl_pkg::*;
#(
	parameter int W = OPERAND_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_sub;
	logic          fits;

	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign done     = busy_q && (cnt_q == CW'(W));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= '0;
		end else if (busy_q && !done) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
			cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule
`default_nettype wire

@@ sv/binary_gcd_and_lcm_32_top.sv @@
// Top level: GCD and LCM of two signed operands under a small sequencer.
// Sequence: load the operands, run the GCD steps in the shift/subtract unit, divide the
//   first magnitude by the GCD, multiply by the second magnitude, then offer the result.
// Throughput: one item at a time; the next item is accepted after the result transfers.
// Both operands zero skip the divider and multiplier.
// Reset: arst_n clears the sequencer and unit busy flags; the block comes up idle.
`timescale 1ns / 1ps
`default_nettype none
module binary_gcd_and_lcm_32_top
	import bgl_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [IN_W-1:0]  operand_a,
	input  wire logic [IN_W-1:0]  operand_b,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [GCD_W-1:0]      gcd_value,
	output logic [LCM_W-1:0]      lcm_value,
	output logic                  lcm_error
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;

	bgl_state_t state_q;
	bgl_state_t state_d;

	logic [W-1:0]  raw_a;
	logic [W-1:0]  raw_b;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W-1:0]  ma_q;
	logic [W-1:0]  mb_q;
	logic [W-1:0]  g_q;
	logic [W-1:0]  quo_q;
	logic [PW-1:0] lcm_q;
	logic          err_q;
	logic [PW-1:0] prod;

	logic          accept;
	logic          gcd_done;
	logic [W-1:0]  gcd_res;
	logic          div_start;
	logic          div_done;
	logic [W-1:0]  div_quo;
	logic          gcd_zero;

	assign raw_a    = operand_a[W-1:0];
	assign raw_b    = operand_b[W-1:0];
	assign mag_a    = raw_a[W-1] ? W'(0) - raw_a : raw_a;
	assign mag_b    = raw_b[W-1] ? W'(0) - raw_b : raw_b;
	assign accept   = in_valid && in_ready;
	assign gcd_zero = gcd_res == '0;
	assign prod     = PW'(quo_q) * PW'(mb_q);

	bgl_gcd #(.W(W)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x_in   (mag_a),
		.y_in   (mag_b),
		.done   (gcd_done),
		.gcd    (gcd_res)
	);

	bgl_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ma_q),
		.divisor  (gcd_res),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_GCD;
				end
			end
			ST_GCD: begin
				if (gcd_done) begin
					if (gcd_zero) begin
						state_d = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ma_q <= mag_a;
			mb_q <= mag_b;
		end
		if (state_q == ST_GCD && gcd_done) begin
			g_q   <= gcd_res;
			err_q <= gcd_zero;
			lcm_q <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			quo_q <= div_quo;
		end
		if (state_q == ST_MUL) begin
			lcm_q <= prod;
		end
	end

	assign gcd_value = GCD_W'(g_q);
	assign lcm_value = LCM_W'(lcm_q);
	assign lcm_error = err_q;

endmodule
`default_nettype wire
